[rtl/crsf_pkg.sv]
// Shared constants, register indexes and the CRC-8 step for the CRSF frame receiver.
// No dependencies; used by crsf_rc_frame_receiver_top.
package crsf_pkg;

  // Frame store geometry.
  localparam int MAX_FRAME_LEN = 64;
  localparam int STORE_AW      = $clog2(MAX_FRAME_LEN);
  localparam int LEN_W         = 7;

  // Protocol constants.
  localparam logic [7:0] CRC_POLY         = 8'hD5;
  localparam logic [7:0] TYPE_RC_CHANNELS = 8'h16;
  localparam int         RC_PAYLOAD_LEN   = 22;
  localparam int         MIN_LEN          = 2;
  localparam int         NUM_CH           = 10;
  localparam int         CH_W             = 11;
  localparam int         IDX_W            = 4;
  localparam logic [23:0] ELAPSED_MAX     = 24'hFFFFFF;

  // Unpack buffer: up to ten leftover bits plus one new byte.
  localparam int BUF_W = CH_W - 1 + 8;
  localparam int CNT_W = $clog2(BUF_W + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_ADDRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_CENTER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_LOW    = 2'd3;

  // Register reset values.
  localparam logic [7:0]      RST_SYNC_ADDRESS    = 8'hC8;
  localparam logic [23:0]     RST_LINK_TIMEOUT    = 24'd100000;
  localparam logic [CH_W-1:0] RST_FAILSAFE_CENTER = 11'd992;
  localparam logic [CH_W-1:0] RST_FAILSAFE_LOW    = 11'd172;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/crsf_rc_frame_receiver_top.sv]
// Top level of the CRSF RC-channels frame receiver: parser, frame store and channel unpacker.
// Depends on crsf_pkg.
//
// Usage:
// The input channel (in_valid / in_stall) carries one word per received serial byte
// (kind = 0) or per microsecond tick (kind = 1). The output channel (out_valid /
// out_stall) carries one channel per word: index, 11-bit value, last_of_run,
// is_failsafe and the link flag. Configuration registers are written through
// cfg_valid / cfg_ready, which is always ready; write only while the block is idle.
// A byte or tick is taken whenever in_stall is low. A byte that completes a good
// RC-channels frame starts a run of ten channels unpacked from the frame store, one
// single-port-read memory: while the receiver does not stall, each cycle of a run
// either reads one byte or emits one channel; a frame run makes 14 store reads and emits
// ten channels. A failsafe run, started by the tick that passes the timeout, emits ten
// channels without store reads. The first frame channel waits for two store reads before
// entering the output register; a failsafe channel needs none. in_stall is high while a
// run is being produced; the next word is taken while the final channel still waits in
// the output register. When the receiver stalls, the output register holds its word
// and the run pauses. Reset clears the parser to hunting, the elapsed count to zero,
// raises the link flag and restores the register defaults; the store is not cleared.
module crsf_rc_frame_receiver_top (
  input  logic                              clk,
  input  logic                              rst,
  // Input words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [7:0]                        data_byte,
  // Output words
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [crsf_pkg::IDX_W-1:0]        channel_index,
  output logic [crsf_pkg::CH_W-1:0]         channel_value,
  output logic                              last_of_run,
  output logic                              is_failsafe,
  output logic                              link_up,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [23:0]                       cfg_data
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam int AW = crsf_pkg::STORE_AW;
  localparam int LW = crsf_pkg::LEN_W;
  localparam logic [crsf_pkg::IDX_W-1:0] LAST_CH = crsf_pkg::IDX_W'(crsf_pkg::NUM_CH - 1);
  localparam logic [LW-1:0] RC_FRAME_LEN = LW'(crsf_pkg::RC_PAYLOAD_LEN + 2);

  // Configuration registers
  logic [7:0]                  sync_address;
  logic [23:0]                 link_timeout;
  logic [crsf_pkg::CH_W-1:0]   failsafe_center;
  logic [crsf_pkg::CH_W-1:0]   failsafe_low;

  // Parser and link state
  logic [1:0]    parse_phase, parse_phase_next;
  logic [LW-1:0] frame_length, frame_length_next;
  logic [LW-1:0] byte_position, byte_position_next;
  logic [7:0]    running_crc, running_crc_next;
  logic [7:0]    type_byte, type_byte_next;
  logic [23:0]   elapsed_ticks, elapsed_ticks_next;
  logic          link_flag, link_flag_next;
  logic          failsafe_sent, failsafe_sent_next;

  // Frame store
  logic [7:0]    frame_store [crsf_pkg::MAX_FRAME_LEN];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_q;

  // Run sequencer
  logic                           run_active, run_active_next;
  logic                           run_fs, run_fs_next;
  logic [crsf_pkg::IDX_W-1:0]     ch_idx, ch_idx_next;
  logic [AW-1:0]                  rd_addr, rd_addr_next;
  logic                           rd_pend, rd_pend_next;
  logic                           rd_en;
  logic [crsf_pkg::BUF_W-1:0]     bitbuf, bitbuf_next, bitbuf_m;
  logic [crsf_pkg::CNT_W-1:0]     bitcnt, bitcnt_next, bitcnt_m;
  logic                           slot_free;
  logic                           emit;
  logic [crsf_pkg::CH_W-1:0]      emit_value;
  logic                           start_frame, start_fs;

  logic          in_acc;
  logic [23:0]   elapsed_inc;
  logic [LW:0]   pos_plus;

  assign cfg_ready = 1'b1;
  assign in_stall  = run_active;
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_address    <= crsf_pkg::RST_SYNC_ADDRESS;
      link_timeout    <= crsf_pkg::RST_LINK_TIMEOUT;
      failsafe_center <= crsf_pkg::RST_FAILSAFE_CENTER;
      failsafe_low    <= crsf_pkg::RST_FAILSAFE_LOW;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        crsf_pkg::REG_SYNC_ADDRESS:    sync_address    <= cfg_data[7:0];
        crsf_pkg::REG_LINK_TIMEOUT:    link_timeout    <= cfg_data;
        crsf_pkg::REG_FAILSAFE_CENTER: failsafe_center <= cfg_data[crsf_pkg::CH_W-1:0];
        crsf_pkg::REG_FAILSAFE_LOW:    failsafe_low    <= cfg_data[crsf_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Parser, CRC and link timer for each accepted word.
  always_comb begin
    parse_phase_next   = parse_phase;
    frame_length_next  = frame_length;
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    type_byte_next     = type_byte;
    elapsed_ticks_next = elapsed_ticks;
    link_flag_next     = link_flag;
    failsafe_sent_next = failsafe_sent;
    wr_en              = 1'b0;
    wr_addr            = byte_position[AW-1:0];
    start_frame        = 1'b0;
    start_fs           = 1'b0;
    elapsed_inc        = (elapsed_ticks == crsf_pkg::ELAPSED_MAX) ? elapsed_ticks
                                                                 : elapsed_ticks + 24'd1;
    pos_plus           = {1'b0, byte_position} + (LW+1)'(1);

    if (in_acc && kind) begin
      // Tick: saturating count, then the timeout check.
      elapsed_ticks_next = elapsed_inc;
      if (elapsed_inc > link_timeout) begin
        link_flag_next = 1'b0;
        if (!failsafe_sent) begin
          failsafe_sent_next = 1'b1;
          start_fs           = 1'b1;
        end
      end else begin
        link_flag_next     = 1'b1;
        failsafe_sent_next = 1'b0;
      end
    end else if (in_acc) begin
      unique case (parse_phase)
        PH_HUNT: begin
          if (data_byte == sync_address) begin
            parse_phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (data_byte < 8'(crsf_pkg::MIN_LEN) || data_byte > 8'(crsf_pkg::MAX_FRAME_LEN)) begin
            parse_phase_next = PH_HUNT;
          end else begin
            frame_length_next  = data_byte[LW-1:0];
            byte_position_next = '0;
            running_crc_next   = 8'h00;
            parse_phase_next   = PH_BODY;
          end
        end
        PH_BODY: begin
          wr_en = 1'b1;
          if (byte_position == '0) begin
            type_byte_next = data_byte;
          end
          if (pos_plus < {1'b0, frame_length}) begin
            running_crc_next   = crsf_pkg::crc8_step(running_crc, data_byte);
            byte_position_next = pos_plus[LW-1:0];
          end else begin
            parse_phase_next = PH_HUNT;
            if (running_crc == data_byte && type_byte == crsf_pkg::TYPE_RC_CHANNELS &&
                frame_length == RC_FRAME_LEN) begin
              elapsed_ticks_next = '0;
              link_flag_next     = 1'b1;
              failsafe_sent_next = 1'b0;
              start_frame        = 1'b1;
            end
          end
        end
        default: begin
          parse_phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_HUNT;
      frame_length  <= '0;
      byte_position <= '0;
      running_crc   <= 8'h00;
      elapsed_ticks <= '0;
      link_flag     <= 1'b1;
      failsafe_sent <= 1'b0;
    end else begin
      parse_phase   <= parse_phase_next;
      frame_length  <= frame_length_next;
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      elapsed_ticks <= elapsed_ticks_next;
      link_flag     <= link_flag_next;
      failsafe_sent <= failsafe_sent_next;
    end
  end

  always_ff @(posedge clk) begin
    type_byte <= type_byte_next;
  end

  // Frame store: one write port for the parser, one registered read port for the unpacker.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[wr_addr] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= frame_store[rd_addr];
    end
  end

  // Run sequencer: merge the byte read last cycle, then either fetch or emit a channel.
  always_comb begin
    run_active_next = run_active;
    run_fs_next     = run_fs;
    ch_idx_next     = ch_idx;
    rd_addr_next    = rd_addr;
    rd_pend_next    = 1'b0;
    rd_en           = 1'b0;
    emit            = 1'b0;
    emit_value      = failsafe_low;

    if (rd_pend) begin
      bitbuf_m = bitbuf | (crsf_pkg::BUF_W'(rd_q) << bitcnt);
      bitcnt_m = bitcnt + crsf_pkg::CNT_W'(8);
    end else begin
      bitbuf_m = bitbuf;
      bitcnt_m = bitcnt;
    end
    bitbuf_next = bitbuf_m;
    bitcnt_next = bitcnt_m;

    if (run_active) begin
      if (run_fs) begin
        emit = slot_free;
        if (ch_idx == 4'd0 || ch_idx == 4'd1 || ch_idx == 4'd3) begin
          emit_value = failsafe_center;
        end
      end else if (bitcnt_m < crsf_pkg::CNT_W'(crsf_pkg::CH_W)) begin
        rd_en        = 1'b1;
        rd_pend_next = 1'b1;
        rd_addr_next = rd_addr + AW'(1);
      end else begin
        emit       = slot_free;
        emit_value = bitbuf_m[crsf_pkg::CH_W-1:0];
        if (slot_free) begin
          bitbuf_next = bitbuf_m >> crsf_pkg::CH_W;
          bitcnt_next = bitcnt_m - crsf_pkg::CNT_W'(crsf_pkg::CH_W);
        end
      end
      if (emit) begin
        ch_idx_next = ch_idx + 4'd1;
        if (ch_idx == LAST_CH) begin
          run_active_next = 1'b0;
        end
      end
    end else if (start_frame || start_fs) begin
      run_active_next = 1'b1;
      run_fs_next     = start_fs;
      ch_idx_next     = '0;
      rd_addr_next    = AW'(1);
      bitbuf_next     = '0;
      bitcnt_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      run_active <= run_active_next;
      rd_pend    <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    run_fs  <= run_fs_next;
    ch_idx  <= ch_idx_next;
    rd_addr <= rd_addr_next;
    bitbuf  <= bitbuf_next;
    bitcnt  <= bitcnt_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      channel_index <= ch_idx;
      channel_value <= emit_value;
      last_of_run   <= (ch_idx == LAST_CH);
      is_failsafe   <= run_fs;
      link_up       <= link_flag;
    end
  end

  // The last channel of a run leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (rst)
    (emit && ch_idx == LAST_CH) |=> !run_active)
    else $error("run still active after its last channel");

  // Store reads belong to frame runs only.
  assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (run_active && !run_fs))
    else $error("store read outside a frame run");

  // A failsafe word never reports the link as up.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_failsafe) |-> !link_up)
    else $error("failsafe word with link up");

  // The channel counter stays within the run while active.
  assert property (@(posedge clk) disable iff (rst)
    run_active |-> (ch_idx <= LAST_CH))
    else $error("channel counter out of range");

  // The unpack buffer never holds more bits than it can.
  assert property (@(posedge clk) disable iff (rst)
    (run_active && !run_fs) |-> (bitcnt < crsf_pkg::CNT_W'(crsf_pkg::CH_W)
                                 || !rd_pend))
    else $error("byte merged into a full unpack buffer");

endmodule

[tb/sv/crsf_rc_frame_receiver_top_tb.sv]
// Self-checking testbench for crsf_rc_frame_receiver_top: directed and random byte/tick words,
// a scoreboard class that predicts every channel word, random sender gaps and receiver stalls.
// Depends on crsf_pkg and rtl/crsf_rc_frame_receiver_top.sv.
module crsf_rc_frame_receiver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RC_FRAME_LEN = crsf_pkg::RC_PAYLOAD_LEN + 2;
  localparam int IDLE_CYCLES  = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [crsf_pkg::IDX_W-1:0] index;
    logic [crsf_pkg::CH_W-1:0]  value;
    logic                       last;
    logic                       failsafe;
    logic                       link;
  } channel_word_t;

  typedef enum logic [1:0] {HUNT_SYNC, READ_LENGTH, READ_BODY} parse_state_t;

  // Predicts the channel words of the receiver and checks the words it produces.
  class crsf_channel_board;
    logic [7:0]                sync_byte     = crsf_pkg::RST_SYNC_ADDRESS;
    logic [23:0]               timeout_ticks = crsf_pkg::RST_LINK_TIMEOUT;
    logic [crsf_pkg::CH_W-1:0] center_value  = crsf_pkg::RST_FAILSAFE_CENTER;
    logic [crsf_pkg::CH_W-1:0] low_value     = crsf_pkg::RST_FAILSAFE_LOW;

    parse_state_t    state         = HUNT_SYNC;
    int unsigned     frame_len     = 0;
    int unsigned     body_pos      = 0;
    logic [7:0]      crc_acc       = 8'h00;
    logic [7:0]      frame_bytes[crsf_pkg::MAX_FRAME_LEN];
    logic [23:0]     elapsed       = 24'd0;
    logic            link          = 1'b1;
    logic            failsafe_done = 1'b0;

    channel_word_t   pending_channels[$];
    int              mismatches    = 0;
    int              runs          = 0;

    // CRC-8, one message bit at a time, MSB first.
    static function logic [7:0] crc_next(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c  = {c[6:0], 1'b0} ^ (fb ? crsf_pkg::CRC_POLY : 8'h00);
      end
      return c;
    endfunction

    function void set_reg(logic [crsf_pkg::CFG_IDX_W-1:0] idx, logic [23:0] d);
      case (idx)
        crsf_pkg::REG_SYNC_ADDRESS:    sync_byte     = d[7:0];
        crsf_pkg::REG_LINK_TIMEOUT:    timeout_ticks = d;
        crsf_pkg::REG_FAILSAFE_CENTER: center_value  = d[crsf_pkg::CH_W-1:0];
        crsf_pkg::REG_FAILSAFE_LOW:    low_value     = d[crsf_pkg::CH_W-1:0];
        default: ;
      endcase
    endfunction

    // Queue ten channels, either unpacked LSB first from the payload or failsafe values.
    function void push_run(bit from_frame);
      logic [8*crsf_pkg::RC_PAYLOAD_LEN-1:0] payload_bits;
      channel_word_t                         w;
      payload_bits = '0;
      if (from_frame) begin
        for (int i = 0; i < crsf_pkg::RC_PAYLOAD_LEN; i++) begin
          payload_bits[8*i +: 8] = frame_bytes[i+1];
        end
      end
      for (int k = 0; k < crsf_pkg::NUM_CH; k++) begin
        w.index = crsf_pkg::IDX_W'(k);
        if (from_frame) begin
          w.value = payload_bits[crsf_pkg::CH_W*k +: crsf_pkg::CH_W];
        end else begin
          w.value = (k == 0 || k == 1 || k == 3) ? center_value : low_value;
        end
        w.last     = (k == crsf_pkg::NUM_CH - 1);
        w.failsafe = !from_frame;
        w.link     = link;
        pending_channels.push_back(w);
      end
      runs++;
    endfunction

    // Advance the predicted state by one accepted input word.
    function void note_word(logic is_tick, logic [7:0] b);
      if (is_tick) begin
        if (elapsed != crsf_pkg::ELAPSED_MAX) elapsed++;
        if (elapsed > timeout_ticks) begin
          link = 1'b0;
          if (!failsafe_done) begin
            failsafe_done = 1'b1;
            push_run(1'b0);
          end
        end else begin
          link          = 1'b1;
          failsafe_done = 1'b0;
        end
        return;
      end
      case (state)
        HUNT_SYNC: begin
          if (b == sync_byte) state = READ_LENGTH;
        end
        READ_LENGTH: begin
          if (b < crsf_pkg::MIN_LEN || b > crsf_pkg::MAX_FRAME_LEN) begin
            state = HUNT_SYNC;
          end else begin
            frame_len = b;
            body_pos  = 0;
            crc_acc   = 8'h00;
            state     = READ_BODY;
          end
        end
        READ_BODY: begin
          frame_bytes[body_pos] = b;
          if (body_pos + 1 < frame_len) begin
            crc_acc = crc_next(crc_acc, b);
            body_pos++;
          end else begin
            state = HUNT_SYNC;
            if (crc_acc == b && frame_bytes[0] == crsf_pkg::TYPE_RC_CHANNELS
                && frame_len == RC_FRAME_LEN) begin
              elapsed       = 24'd0;
              link          = 1'b1;
              failsafe_done = 1'b0;
              push_run(1'b1);
            end
          end
        end
        default: state = HUNT_SYNC;
      endcase
    endfunction

    // Compare one produced channel word with the oldest prediction.
    function void check_channel(channel_word_t got);
      channel_word_t want;
      if (pending_channels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: unexpected channel word: index %0d value %0d last %0b fs %0b link %0b",
                   $realtime, got.index, got.value, got.last, got.failsafe, got.link);
        end
        return;
      end
      want = pending_channels.pop_front();
      if (got.index !== want.index || got.value !== want.value || got.last !== want.last
          || got.failsafe !== want.failsafe || got.link !== want.link) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: channel mismatch: expected index %0d value %0d last %0b fs %0b link %0b",
                   $realtime, want.index, want.value, want.last, want.failsafe, want.link);
          $display("%0t:                   actual index %0d value %0d last %0b fs %0b link %0b",
                   $realtime, got.index, got.value, got.last, got.failsafe, got.link);
        end
      end
    endfunction
  endclass

  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           in_valid      = 1'b0;
  logic                           in_stall;
  logic                           kind          = 1'b0;
  logic [7:0]                     data_byte     = 8'h00;
  logic                           out_valid;
  logic                           out_stall     = 1'b0;
  logic [crsf_pkg::IDX_W-1:0]     channel_index;
  logic [crsf_pkg::CH_W-1:0]      channel_value;
  logic                           last_of_run;
  logic                           is_failsafe;
  logic                           link_up;
  logic                           cfg_valid     = 1'b0;
  logic                           cfg_ready;
  logic [crsf_pkg::CFG_IDX_W-1:0] cfg_index     = crsf_pkg::REG_SYNC_ADDRESS;
  logic [23:0]                    cfg_data      = 24'd0;

  crsf_channel_board board = new();

  int         burst_left = 0;
  int         items_sent = 0;
  bit         mix_ticks  = 1'b0;
  logic [7:0] cur_sync   = crsf_pkg::RST_SYNC_ADDRESS;
  int         stall_mode = 0;
  int         stall_left = 0;

  crsf_rc_frame_receiver_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_of_run   (last_of_run),
    .is_failsafe   (is_failsafe),
    .link_up       (link_up),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Watch both channels; results are checked before the new input word is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        board.check_channel({channel_index, channel_value, last_of_run, is_failsafe, link_up});
      end
      if (in_valid && !in_stall) board.note_word(kind, data_byte);
    end
  end

  // Receiver stall pattern: free running, light, heavy or periodic, switching now and then.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 5 < 2);
    endcase
  end

  // Offer one word and hold it until accepted; bursts are separated by random gaps.
  task automatic send_word(logic k, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    kind      <= k;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_tick();
    send_word(1'b1, 8'($urandom));
  endtask

  // A serial byte, sometimes preceded by a tick when ticks are mixed into the stream.
  task automatic send_byte(logic [7:0] b);
    if (mix_ticks && $urandom_range(0, 9) == 0) send_tick();
    send_word(1'b0, b);
  endtask

  // Complete frame: sync, length, type, payload and CRC, optionally with a flipped CRC bit.
  task automatic send_frame(int len, logic [7:0] ftype, bit corrupt, bit ones);
    logic [7:0] crc;
    logic [7:0] b;
    crc = crsf_channel_board::crc_next(8'h00, ftype);
    send_byte(cur_sync);
    send_byte(8'(len));
    send_byte(ftype);
    for (int i = 0; i < len - 2; i++) begin
      b   = ones ? 8'hFF : 8'($urandom);
      crc = crsf_channel_board::crc_next(crc, b);
      send_byte(b);
    end
    if (corrupt) crc ^= 8'(1 << $urandom_range(0, 7));
    send_byte(crc);
  endtask

  // Let every predicted channel drain, then give the block time to settle.
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending_channels.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [crsf_pkg::CFG_IDX_W-1:0] idx, logic [23:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, d);
  endtask

  task automatic configure(logic [7:0] s, logic [23:0] t, logic [crsf_pkg::CH_W-1:0] c,
                           logic [crsf_pkg::CH_W-1:0] l);
    wait_idle();
    write_reg(crsf_pkg::REG_SYNC_ADDRESS, 24'(s));
    write_reg(crsf_pkg::REG_LINK_TIMEOUT, t);
    write_reg(crsf_pkg::REG_FAILSAFE_CENTER, 24'(c));
    write_reg(crsf_pkg::REG_FAILSAFE_LOW, 24'(l));
    cfg_valid <= 1'b0;
    cur_sync  = s;
  endtask

  // Good channel frames half of the time, plus broken frames, tick bursts and stray bytes.
  task automatic random_phase(int target);
    int start_items;
    int start_runs;
    int pick;
    start_items = items_sent;
    start_runs  = board.runs;
    while ((items_sent - start_items < target || board.runs - start_runs < 1)
           && items_sent - start_items < 120) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_frame(RC_FRAME_LEN, crsf_pkg::TYPE_RC_CHANNELS, 1'b0, 1'b0);
      end else if (pick < 65) begin
        case ($urandom_range(0, 2))
          0: send_frame(RC_FRAME_LEN, 8'($urandom), 1'b0, 1'b0);
          1: send_frame(RC_FRAME_LEN, crsf_pkg::TYPE_RC_CHANNELS, 1'b1, 1'b0);
          default: send_frame(($urandom_range(0, 3) == 0) ? crsf_pkg::MAX_FRAME_LEN
                                : $urandom_range(crsf_pkg::MIN_LEN, crsf_pkg::MAX_FRAME_LEN),
                              8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
        endcase
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_tick();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: send_byte(8'($urandom));
            1: send_byte(cur_sync);
            default: send_byte(($urandom_range(0, 1) == 1)
                                 ? 8'($urandom_range(0, crsf_pkg::MIN_LEN - 1))
                                 : 8'($urandom_range(crsf_pkg::MAX_FRAME_LEN + 1, 255)));
          endcase
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Default registers: parser corner cases, then the shortest frame and an all-ones frame.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_sync);
    send_byte(8'(crsf_pkg::MIN_LEN - 1));
    send_byte(cur_sync);
    send_byte(8'(crsf_pkg::MAX_FRAME_LEN + 1));
    // A sync byte in the length slot is rejected and not taken as a new sync.
    send_byte(cur_sync);
    send_byte(cur_sync);
    send_byte(8'(RC_FRAME_LEN));
    send_frame(crsf_pkg::MIN_LEN, crsf_pkg::TYPE_RC_CHANNELS, 1'b0, 1'b0);
    send_frame(RC_FRAME_LEN, crsf_pkg::TYPE_RC_CHANNELS, 1'b0, 1'b1);
    send_tick();

    // Timeout of one tick: failsafe on the second tick after the last frame, and only once.
    configure(8'h00, 24'd1, 11'd0, 11'd2047);
    repeat (3) send_tick();
    mix_ticks = 1'b1;
    random_phase(20);

    // Longest timeout: the first tick brings the link back and re-arms failsafe.
    configure(8'hFF, 24'hFFFFFF, 11'd2047, 11'd0);
    send_tick();
    random_phase(20);

    configure(8'($urandom), 24'($urandom_range(5, 60)), 11'($urandom), 11'($urandom));
    random_phase(20);

    configure(crsf_pkg::RST_SYNC_ADDRESS, 24'd20, crsf_pkg::RST_FAILSAFE_CENTER,
              crsf_pkg::RST_FAILSAFE_LOW);
    random_phase(20);

    wait_idle();
    if (board.mismatches == 0 && board.pending_channels.size() == 0) begin
      $display("crsf_rc_frame_receiver_top test passed");
    end else begin
      $display("crsf_rc_frame_receiver_top test failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("crsf_rc_frame_receiver_top test failed");
    $finish;
  end

endmodule
